// ----- design/tce_pkg.sv -----
package tce_pkg;

  // Fixed field widths.
  localparam int unsigned REQ_W   = 2;
  localparam int unsigned CHAR_W  = 8;
  localparam int unsigned ATTR_W  = 8;
  localparam int unsigned SEL_W   = 2;
  localparam int unsigned TCOL_W  = 7;
  localparam int unsigned TROW_W  = 5;
  localparam int unsigned IDX_W   = 11;
  localparam int unsigned CELL_W  = CHAR_W + ATTR_W;
  localparam int unsigned CFG_IDX_W = 2;

  // Request kinds.
  typedef enum logic [REQ_W-1:0] {
    REQ_PUT   = 2'd0,
    REQ_CLEAR = 2'd1,
    REQ_MOVE  = 2'd2,
    REQ_READ  = 2'd3
  } req_e;

  // Character codes with special meaning.
  localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
  localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

  // Palette selections.
  localparam logic [SEL_W-1:0] SEL_NORMAL = 2'd0;
  localparam logic [SEL_W-1:0] SEL_KERNEL = 2'd1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_COLOR_NORMAL  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLOR_KERNEL  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COLOR_PROGRAM = 2'd2;

  // Reset attributes.
  localparam logic [ATTR_W-1:0] COLOR_NORMAL_RST  = 8'd7;
  localparam logic [ATTR_W-1:0] COLOR_KERNEL_RST  = 8'd4;
  localparam logic [ATTR_W-1:0] COLOR_PROGRAM_RST = 8'd2;

  // Top-level control states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_SWEEP
  } ctl_state_e;

  // Sweep engine phases.
  typedef enum logic [1:0] {
    SW_IDLE,
    SW_FILL,
    SW_COPY,
    SW_BLANK
  } sw_phase_e;

  typedef struct packed {
    logic              go;
    logic              scroll;
    logic [ATTR_W-1:0] attr;
  } sweep_cmd_t;

  typedef struct packed {
    logic busy;
    logic done;
  } sweep_stat_t;

endpackage

// ----- design/tce_cell_ram.sv -----
module tce_cell_ram #(
  parameter int unsigned DEPTH  = 2000,
  parameter int unsigned ADDR_W = 11
) (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic [ADDR_W-1:0]          waddr_i,
  input  logic [tce_pkg::CELL_W-1:0] wdata_i,
  input  logic                       re_i,
  input  logic [ADDR_W-1:0]          raddr_i,
  output logic [tce_pkg::CELL_W-1:0] rdata_o
);
  import tce_pkg::*;

  // Each entry holds the attribute in the upper byte and the character below.
  logic [CELL_W-1:0] mem [DEPTH];
  logic [CELL_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- design/tce_sweep.sv -----
module tce_sweep #(
  parameter int unsigned SCREEN_COLS = 80,
  parameter int unsigned SCREEN_ROWS = 25,
  parameter int unsigned ADDR_W      = 11
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  tce_pkg::sweep_cmd_t        cmd_i,
  output tce_pkg::sweep_stat_t       stat_o,
  input  logic [tce_pkg::CELL_W-1:0] rdata_i,
  output logic                       we_o,
  output logic [ADDR_W-1:0]          waddr_o,
  output logic [tce_pkg::CELL_W-1:0] wdata_o,
  output logic                       re_o,
  output logic [ADDR_W-1:0]          raddr_o
);
  import tce_pkg::*;

  localparam int unsigned CELLS = SCREEN_COLS * SCREEN_ROWS;
  localparam int unsigned LAST  = (SCREEN_ROWS - 1) * SCREEN_COLS;

  sw_phase_e         phase_q, phase_d;
  logic [ADDR_W-1:0] ptr_q, ptr_d;
  logic [ATTR_W-1:0] attr_q, attr_d;
  logic              cp_wr_q, cp_wr_d;
  logic [ADDR_W-1:0] cp_addr_q, cp_addr_d;
  logic              done;

  // The copy pass reads one row ahead and writes the cell it read in the following
  // cycle, so the write address always trails the read address.
  always_comb begin
    phase_d   = phase_q;
    ptr_d     = ptr_q;
    attr_d    = attr_q;
    cp_wr_d   = 1'b0;
    cp_addr_d = cp_addr_q;
    done      = 1'b0;
    we_o      = 1'b0;
    waddr_o   = ptr_q;
    wdata_o   = {attr_q, CH_NUL};
    re_o      = 1'b0;
    raddr_o   = ptr_q + ADDR_W'(SCREEN_COLS);
    case (phase_q)
      SW_IDLE: begin
        if (cmd_i.go) begin
          attr_d  = cmd_i.attr;
          ptr_d   = '0;
          phase_d = cmd_i.scroll ? SW_COPY : SW_FILL;
        end
      end
      SW_FILL: begin
        we_o = 1'b1;
        if (ptr_q == ADDR_W'(CELLS - 1)) begin
          done    = 1'b1;
          phase_d = SW_IDLE;
        end else begin
          ptr_d = ptr_q + ADDR_W'(1);
        end
      end
      SW_COPY: begin
        if (cp_wr_q) begin
          we_o    = 1'b1;
          waddr_o = cp_addr_q;
          wdata_o = rdata_i;
        end
        if (ptr_q != ADDR_W'(LAST)) begin
          re_o      = 1'b1;
          cp_wr_d   = 1'b1;
          cp_addr_d = ptr_q;
          ptr_d     = ptr_q + ADDR_W'(1);
        end else begin
          phase_d = SW_BLANK;
        end
      end
      SW_BLANK: begin
        we_o    = 1'b1;
        wdata_o = {attr_q, CH_SPACE};
        if (ptr_q == ADDR_W'(CELLS - 1)) begin
          done    = 1'b1;
          phase_d = SW_IDLE;
        end else begin
          ptr_d = ptr_q + ADDR_W'(1);
        end
      end
      default: begin
        phase_d = SW_IDLE;
      end
    endcase
  end

  // Out of reset the engine runs a fill pass with the program color.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= SW_FILL;
      ptr_q   <= '0;
      attr_q  <= COLOR_PROGRAM_RST;
      cp_wr_q <= 1'b0;
    end else begin
      phase_q <= phase_d;
      ptr_q   <= ptr_d;
      attr_q  <= attr_d;
      cp_wr_q <= cp_wr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cp_addr_q <= cp_addr_d;
  end

  assign stat_o.busy = (phase_q != SW_IDLE);
  assign stat_o.done = done;

endmodule

// ----- design/text_console_engine.sv -----
// Results: put, move and ignored items register their result when the input word is taken;
// a cell read waits in ST_READ for the memory data; clear and a put that scrolls give theirs
// when the sweep engine is done, as it walks the cells through the single write port of the
// cell memory. Items are taken one at a time; moves and puts that do not scroll can follow
// each other back to back while the result drains. Reset: cursor homes, palette returns to
// 7/4/2, and a fill pass writes code 0 in attribute 2 to every cell with s_axis_tready held low.
module text_console_engine #(
  parameter int unsigned SCREEN_COLS = 80,
  parameter int unsigned SCREEN_ROWS = 25,
  parameter int unsigned TAB_STOP    = 8
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // Input words.
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // tdata: char_code[7:0], color_sel[9:8], target_col[16:10], target_row[21:17], zero pad.
  input  logic [23:0]                      s_axis_tdata,
  // tuser: req_type[1:0].
  input  logic [tce_pkg::REQ_W-1:0]        s_axis_tuser,
  // Result words.
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // tdata: cursor_index[10:0], read_char[18:11], read_color[26:19], zero pad.
  output logic [31:0]                      m_axis_tdata,
  // tuser: cell_written.
  output logic                             m_axis_tuser,
  // Palette configuration.
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [tce_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [tce_pkg::ATTR_W-1:0]       cfg_data_i
);
  import tce_pkg::*;

  localparam int unsigned CELLS  = SCREEN_COLS * SCREEN_ROWS;
  localparam int unsigned ADDR_W = $clog2(CELLS);
  localparam int unsigned COL_W  = $clog2(SCREEN_COLS);
  localparam int unsigned ROW_W  = $clog2(SCREEN_ROWS);
  // A tab can push the column up to SCREEN_COLS + TAB_STOP - 1 before the wrap.
  localparam int unsigned COLX_W = $clog2(SCREEN_COLS + TAB_STOP);
  localparam int unsigned NSTOP  = ((SCREEN_COLS - 1) / TAB_STOP > 0) ?
                                   (SCREEN_COLS - 1) / TAB_STOP : 1;
  localparam int unsigned CNT_W  = $clog2(NSTOP + 1);

  // Unpacked input fields.
  logic [CHAR_W-1:0] char_code;
  logic [SEL_W-1:0]  color_sel;
  logic [TCOL_W-1:0] target_col;
  logic [TROW_W-1:0] target_row;
  req_e              req_type;

  assign char_code  = s_axis_tdata[7:0];
  assign color_sel  = s_axis_tdata[9:8];
  assign target_col = s_axis_tdata[16:10];
  assign target_row = s_axis_tdata[21:17];
  assign req_type   = req_e'(s_axis_tuser);

  ctl_state_e        state_q, state_d;
  logic [COL_W-1:0]  col_q, col_d;
  logic [ROW_W-1:0]  row_q, row_d;
  logic [ATTR_W-1:0] color_normal_q, color_kernel_q, color_program_q;
  logic              m_valid_q, m_valid_d;
  logic [IDX_W-1:0]  idx_q, idx_d;
  logic              wr_q, wr_d;
  logic [CHAR_W-1:0] rch_q, rch_d;
  logic [ATTR_W-1:0] rat_q, rat_d;

  logic              s_acc;
  logic [ATTR_W-1:0] at;
  logic [COL_W-1:0]  tcol_c;
  logic [ROW_W-1:0]  trow_c;
  logic [ADDR_W-1:0] cur_addr, tgt_addr;
  logic [COLX_W-1:0] tab_next;

  // Result of a put on the current cursor.
  logic [COL_W-1:0]  put_col;
  logic [ROW_W-1:0]  put_row;
  logic              put_we;
  logic [ADDR_W-1:0] put_waddr;
  logic [CELL_W-1:0] put_wdata;
  logic              put_scroll;

  // Memory ports, shared by the item logic and the sweep engine.
  logic              top_we, top_re;
  logic              sw_we, sw_re;
  logic [ADDR_W-1:0] sw_waddr, sw_raddr;
  logic [CELL_W-1:0] sw_wdata;
  logic              ram_we, ram_re;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [CELL_W-1:0] ram_wdata, ram_rdata;

  sweep_cmd_t  sw_cmd;
  sweep_stat_t sw_stat;

  // Items are taken one at a time, only when the sweep engine is quiet and the
  // output register is empty or being emptied in this cycle.
  assign s_axis_tready = (state_q == ST_IDLE) && !sw_stat.busy &&
                         (!m_valid_q || m_axis_tready);
  assign s_acc         = s_axis_tvalid && s_axis_tready;

  // Palette selection three has no entry of its own and falls back to the program color.
  assign at = (color_sel == SEL_NORMAL) ? color_normal_q :
              (color_sel == SEL_KERNEL) ? color_kernel_q : color_program_q;

  // Moves and reads clamp their target to the screen.
  assign tcol_c = (int'(target_col) > SCREEN_COLS - 1) ? COL_W'(SCREEN_COLS - 1)
                                                       : COL_W'(target_col);
  assign trow_c = (int'(target_row) > SCREEN_ROWS - 1) ? ROW_W'(SCREEN_ROWS - 1)
                                                       : ROW_W'(target_row);

  assign cur_addr = ADDR_W'(int'(row_q) * SCREEN_COLS + int'(col_q));
  assign tgt_addr = ADDR_W'(int'(trow_c) * SCREEN_COLS + int'(tcol_c));

  // Next tab stop: count the stops at or below the column and step one stop past them.
  always_comb begin
    logic [CNT_W-1:0] cnt;
    cnt = '0;
    for (int k = 1; k <= NSTOP; k++) begin
      if (k * TAB_STOP <= int'(col_q)) begin
        cnt = cnt + CNT_W'(1);
      end
    end
    tab_next = COLX_W'((int'(cnt) + 1) * TAB_STOP);
  end

  // Character handling. The column is carried in COLX_W bits, wide enough for SCREEN_COLS +
  // TAB_STOP - 1, so that a wrap past the right edge can be seen before it folds into a new line.
  always_comb begin
    logic [COLX_W-1:0] col_x;
    logic              nl;
    col_x      = COLX_W'(col_q);
    nl         = 1'b0;
    put_row    = row_q;
    put_we     = 1'b0;
    put_waddr  = cur_addr;
    put_wdata  = {at, char_code};
    put_scroll = 1'b0;
    if (char_code != CH_NUL) begin
      case (char_code)
        CH_TAB: begin
          col_x = tab_next;
        end
        CH_CR: begin
          col_x = '0;
        end
        CH_LF: begin
          nl = 1'b1;
        end
        CH_BS: begin
          // Backspace at the left edge changes nothing.
          if (col_q != '0) begin
            col_x     = COLX_W'(col_q) - COLX_W'(1);
            put_we    = 1'b1;
            put_waddr = cur_addr - ADDR_W'(1);
            put_wdata = {at, CH_SPACE};
          end
        end
        default: begin
          put_we = 1'b1;
          col_x  = COLX_W'(col_q) + COLX_W'(1);
        end
      endcase
      if (col_x >= COLX_W'(SCREEN_COLS)) begin
        nl = 1'b1;
      end
      if (nl) begin
        col_x = '0;
        if (row_q != ROW_W'(SCREEN_ROWS - 1)) begin
          put_row = row_q + ROW_W'(1);
        end else begin
          // New line on the bottom row: the screen scrolls and the cursor stays on it.
          put_scroll = 1'b1;
        end
      end
    end
    put_col = COL_W'(col_x);
  end

  // Control: takes an item, issues its memory access, and launches the sweep
  // engine for clears and scrolls. The result payload is loaded when the item
  // is taken; read data joins it in the following cycle, from ST_READ.
  always_comb begin
    state_d   = state_q;
    col_d     = col_q;
    row_d     = row_q;
    m_valid_d = m_valid_q && !m_axis_tready;
    idx_d     = idx_q;
    wr_d      = wr_q;
    rch_d     = rch_q;
    rat_d     = rat_q;
    top_we    = 1'b0;
    top_re    = 1'b0;
    sw_cmd    = '0;
    case (state_q)
      ST_IDLE: begin
        if (s_acc) begin
          wr_d  = 1'b0;
          rch_d = '0;
          rat_d = '0;
          case (req_type)
            REQ_PUT: begin
              col_d  = put_col;
              row_d  = put_row;
              top_we = put_we;
              wr_d   = put_we;
              if (put_scroll) begin
                sw_cmd.go     = 1'b1;
                sw_cmd.scroll = 1'b1;
                sw_cmd.attr   = at;
                state_d       = ST_SWEEP;
              end else begin
                m_valid_d = 1'b1;
              end
            end
            REQ_CLEAR: begin
              col_d         = '0;
              row_d         = '0;
              sw_cmd.go     = 1'b1;
              sw_cmd.scroll = 1'b0;
              sw_cmd.attr   = color_program_q;
              state_d       = ST_SWEEP;
            end
            REQ_MOVE: begin
              col_d     = tcol_c;
              row_d     = trow_c;
              m_valid_d = 1'b1;
            end
            REQ_READ: begin
              top_re  = 1'b1;
              state_d = ST_READ;
            end
            default: begin
              m_valid_d = 1'b1;
            end
          endcase
          idx_d = IDX_W'(int'(row_d) * SCREEN_COLS + int'(col_d));
        end
      end
      ST_READ: begin
        rch_d     = ram_rdata[CHAR_W-1:0];
        rat_d     = ram_rdata[CELL_W-1:CHAR_W];
        m_valid_d = 1'b1;
        state_d   = ST_IDLE;
      end
      ST_SWEEP: begin
        if (sw_stat.done) begin
          m_valid_d = 1'b1;
          state_d   = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      col_q     <= '0;
      row_q     <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      col_q     <= col_d;
      row_q     <= row_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    wr_q  <= wr_d;
    rch_q <= rch_d;
    rat_q <= rat_d;
  end

  // Palette registers. Writes to an index past the list are dropped.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      color_normal_q  <= COLOR_NORMAL_RST;
      color_kernel_q  <= COLOR_KERNEL_RST;
      color_program_q <= COLOR_PROGRAM_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_COLOR_NORMAL:  color_normal_q  <= cfg_data_i;
        CFG_COLOR_KERNEL:  color_kernel_q  <= cfg_data_i;
        CFG_COLOR_PROGRAM: color_program_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // The item logic only touches the memory while the sweep engine is idle, so
  // the two never drive a port in the same cycle.
  assign ram_we    = top_we | sw_we;
  assign ram_waddr = top_we ? put_waddr : sw_waddr;
  assign ram_wdata = top_we ? put_wdata : sw_wdata;
  assign ram_re    = top_re | sw_re;
  assign ram_raddr = top_re ? tgt_addr : sw_raddr;

  tce_sweep #(
    .SCREEN_COLS (SCREEN_COLS),
    .SCREEN_ROWS (SCREEN_ROWS),
    .ADDR_W      (ADDR_W)
  ) u_sweep (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (sw_cmd),
    .stat_o  (sw_stat),
    .rdata_i (ram_rdata),
    .we_o    (sw_we),
    .waddr_o (sw_waddr),
    .wdata_o (sw_wdata),
    .re_o    (sw_re),
    .raddr_o (sw_raddr)
  );

  tce_cell_ram #(
    .DEPTH  (CELLS),
    .ADDR_W (ADDR_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {5'b0, rat_q, rch_q, idx_q};
  assign m_axis_tuser  = wr_q;

  // The cursor never leaves the screen.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (col_q <= COL_W'(SCREEN_COLS - 1)) && (row_q <= ROW_W'(SCREEN_ROWS - 1)))
    else $error("cursor outside the screen");

  // Item writes and sweep writes never collide on the write port.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(top_we && sw_we))
    else $error("write port driven by item logic and sweep engine together");

  // No result is offered while a clear or scroll is still rewriting the memory.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SWEEP) && sw_stat.busy |-> !m_valid_q)
    else $error("result offered during a sweep");

endmodule

// ----- verif/text_console_engine_test.sv -----
module text_console_engine_test;
  import tce_pkg::*;

  // Screen geometry, kept equal to the parameters given to the instance below.
  localparam int unsigned COLS      = 80;
  localparam int unsigned ROWS      = 25;
  localparam int unsigned TAB_WIDTH = 8;
  localparam int unsigned CELLS     = COLS * ROWS;

  // Each scroll or clear walks the whole cell store. The random traffic is held to a fixed
  // number of these sweeps so the run stays short, and the cycle limit is several times the
  // slowest run that this number allows.
  localparam int unsigned SWEEP_BUDGET  = 250;
  localparam int unsigned CYCLE_LIMIT   = 4_000_000;
  localparam int unsigned PHASE_WORDS   = 300;
  localparam int unsigned RANDOM_PHASES = 6;
  localparam int unsigned REPORT_LIMIT  = 10;
  localparam int unsigned SETTLE_CYCLES = 20;

  // Palette selections and the register index that the package does not name.
  localparam logic [SEL_W-1:0]     SEL_PROGRAM = 2'd2;
  localparam logic [SEL_W-1:0]     SEL_SPARE   = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE   = 2'd3;

  // One console request as it travels on the input stream.
  typedef struct {
    req_e              req;
    logic [CHAR_W-1:0] code;
    logic [SEL_W-1:0]  sel;
    logic [TCOL_W-1:0] col;
    logic [TROW_W-1:0] row;
  } console_req_t;

  // One result word, field by field.
  typedef struct {
    logic [IDX_W-1:0]  cursor;
    logic              written;
    logic [CHAR_W-1:0] code;
    logic [ATTR_W-1:0] attr;
  } console_resp_t;

  // Clock, reset and every input of the block start at known values.
  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [23:0]          s_axis_tdata  = '0;
  logic [REQ_W-1:0]     s_axis_tuser  = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [31:0]          m_axis_tdata;
  logic                 m_axis_tuser;
  logic                 cfg_valid_i   = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i   = '0;
  logic [ATTR_W-1:0]    cfg_data_i    = '0;

  // Shadow copy of the console: cell store, cursor and palette as the block should hold them.
  logic [CHAR_W-1:0] shadow_code [CELLS];
  logic [ATTR_W-1:0] shadow_attr [CELLS];
  int unsigned       cur_col;
  int unsigned       cur_row;
  logic [ATTR_W-1:0] palette [3];

  // Results predicted for accepted words, oldest first.
  console_resp_t awaited_resps [$];

  int unsigned mismatches  = 0;
  int unsigned sweeps_used = 0;
  int unsigned cycle_count = 0;
  // While set, neither side idles: this gives the long stretch at full rate.
  bit          steady      = 1'b0;

  text_console_engine #(
    .SCREEN_COLS(COLS),
    .SCREEN_ROWS(ROWS),
    .TAB_STOP   (TAB_WIDTH)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // The result side stalls about 30 percent of the time, except in the steady stretch.
  always @(posedge clk_i) begin
    m_axis_tready <= steady || ($urandom_range(0, 99) >= 30);
  end

  // A hung block ends the run here.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic console_req_t mk(req_e req, logic [CHAR_W-1:0] code,
                                      logic [SEL_W-1:0] sel, int unsigned col,
                                      int unsigned row);
    console_req_t r;
    r.req  = req;
    r.code = code;
    r.sel  = sel;
    r.col  = TCOL_W'(col);
    r.row  = TROW_W'(row);
    return r;
  endfunction

  function automatic void fill_screen(logic [CHAR_W-1:0] code, logic [ATTR_W-1:0] attr);
    for (int i = 0; i < CELLS; i++) begin
      shadow_code[i] = code;
      shadow_attr[i] = attr;
    end
  endfunction

  // Works out the effect of one accepted word on the shadow console and queues the result
  // that the block must give for it.
  function automatic void apply_request(console_req_t r);
    console_resp_t     resp;
    logic [ATTR_W-1:0] attr;
    int unsigned       tcol;
    int unsigned       trow;
    int unsigned       here;
    // Selection 3 has no palette entry of its own and falls back to the program colour.
    attr = (r.sel >= SEL_PROGRAM) ? palette[CFG_COLOR_PROGRAM] : palette[r.sel];
    tcol = (r.col > COLS - 1) ? COLS - 1 : r.col;
    trow = (r.row > ROWS - 1) ? ROWS - 1 : r.row;
    resp = '{default: '0};
    case (r.req)
      REQ_PUT: begin
        if (r.code != CH_NUL) begin
          here = cur_row * COLS + cur_col;
          case (r.code)
            CH_TAB: cur_col = (cur_col / TAB_WIDTH + 1) * TAB_WIDTH;
            CH_CR:  cur_col = 0;
            CH_LF:  ;
            CH_BS: begin
              // A backspace at the left edge does nothing at all.
              if (cur_col > 0) begin
                cur_col--;
                shadow_code[here - 1] = CH_SPACE;
                shadow_attr[here - 1] = attr;
                resp.written = 1'b1;
              end
            end
            default: begin
              shadow_code[here] = r.code;
              shadow_attr[here] = attr;
              resp.written = 1'b1;
              cur_col++;
            end
          endcase
          // A new line on the bottom row scrolls everything up one row and blanks the
          // bottom row in the colour of this word.
          if (cur_col >= COLS || r.code == CH_LF) begin
            cur_col = 0;
            if (cur_row < ROWS - 1) begin
              cur_row++;
            end else begin
              for (int i = 0; i < CELLS - COLS; i++) begin
                shadow_code[i] = shadow_code[i + COLS];
                shadow_attr[i] = shadow_attr[i + COLS];
              end
              for (int i = CELLS - COLS; i < CELLS; i++) begin
                shadow_code[i] = CH_SPACE;
                shadow_attr[i] = attr;
              end
            end
          end
        end
      end
      REQ_CLEAR: begin
        fill_screen(CH_NUL, palette[CFG_COLOR_PROGRAM]);
        cur_col = 0;
        cur_row = 0;
      end
      REQ_MOVE: begin
        cur_col = tcol;
        cur_row = trow;
      end
      default: begin
        // A cell read leaves the cursor where it is.
        resp.code = shadow_code[trow * COLS + tcol];
        resp.attr = shadow_attr[trow * COLS + tcol];
      end
    endcase
    resp.cursor = IDX_W'(cur_row * COLS + cur_col);
    awaited_resps.push_back(resp);
  endfunction

  // Keeps the random traffic within its sweep budget: once the budget is spent, a put that
  // would scroll becomes a carriage return and a clear becomes a cell read.
  function automatic console_req_t limit_sweeps(console_req_t r);
    logic sweeps;
    sweeps = 1'b0;
    if (r.req == REQ_CLEAR) begin
      sweeps = 1'b1;
    end else if (r.req == REQ_PUT && cur_row == ROWS - 1) begin
      case (r.code)
        CH_NUL, CH_CR, CH_BS: sweeps = 1'b0;
        CH_LF:                sweeps = 1'b1;
        CH_TAB:               sweeps = ((cur_col / TAB_WIDTH + 1) * TAB_WIDTH >= COLS);
        default:              sweeps = (cur_col == COLS - 1);
      endcase
    end
    if (sweeps) begin
      if (sweeps_used >= SWEEP_BUDGET) begin
        if (r.req == REQ_CLEAR) begin
          r.req = REQ_READ;
        end else begin
          r.code = CH_CR;
        end
      end else begin
        sweeps_used++;
      end
    end
    return r;
  endfunction

  function automatic void flag_mismatch(string msg);
    mismatches++;
    if (mismatches <= REPORT_LIMIT) begin
      $display("mismatch at cycle %0d: %s", cycle_count, msg);
    end
  endfunction

  // Each result word is held against the oldest prediction.
  // Result tdata: cursor_index[10:0], read_char[18:11], read_color[26:19]; tuser: cell_written.
  always @(posedge clk_i) begin : check_results
    console_resp_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (awaited_resps.size() == 0) begin
        flag_mismatch($sformatf("unexpected result cursor=%0d written=%0b char=%02h attr=%02h",
                                m_axis_tdata[10:0], m_axis_tuser, m_axis_tdata[18:11],
                                m_axis_tdata[26:19]));
      end else begin
        want = awaited_resps.pop_front();
        if (m_axis_tdata[10:0] !== want.cursor || m_axis_tuser !== want.written ||
            m_axis_tdata[18:11] !== want.code || m_axis_tdata[26:19] !== want.attr) begin
          flag_mismatch($sformatf({"expected cursor=%0d written=%0b char=%02h attr=%02h, ",
                                   "got cursor=%0d written=%0b char=%02h attr=%02h"},
                                  want.cursor, want.written, want.code, want.attr,
                                  m_axis_tdata[10:0], m_axis_tuser, m_axis_tdata[18:11],
                                  m_axis_tdata[26:19]));
        end
      end
    end
  end

  // Sends one word, with a random idle gap in front of it outside the steady stretch. The
  // valid stays high after the handshake so that back-to-back words need no second update.
  task automatic send_request(console_req_t r);
    if (!steady && $urandom_range(0, 99) < 30) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= r.req;
    // Input tdata: char_code, color_sel, target_col, target_row from bit 0 up, zero pad.
    s_axis_tdata  <= {2'b00, r.row, r.col, r.sel, r.code};
    do @(posedge clk_i); while (!s_axis_tready);
    apply_request(r);
  endtask

  // Stops sending until every predicted result has come back.
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (awaited_resps.size() != 0);
  endtask

  task automatic write_register(logic [CFG_IDX_W-1:0] index, logic [ATTR_W-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    // The spare index has no register behind it and must change nothing.
    if (index != CFG_SPARE) begin
      palette[index] = value;
    end
  endtask

  // Writes all three palette registers and the unused index; the block must be idle.
  task automatic load_palette(logic [ATTR_W-1:0] normal, logic [ATTR_W-1:0] kernel,
                              logic [ATTR_W-1:0] prog);
    write_register(CFG_COLOR_NORMAL, normal);
    write_register(CFG_SPARE, ATTR_W'($urandom));
    write_register(CFG_COLOR_KERNEL, kernel);
    write_register(CFG_COLOR_PROGRAM, prog);
    cfg_valid_i <= 1'b0;
  endtask

  // After reset every cell holds code 0 in attribute 2; reads touch the top-left corner, the
  // clamped far corner and the centre.
  task automatic check_reset_state();
    send_request(mk(REQ_READ, CH_NUL, SEL_NORMAL, 0, 0));
    send_request(mk(REQ_READ, 8'hFF, SEL_SPARE, 127, 31));
    send_request(mk(REQ_READ, CH_NUL, SEL_KERNEL, 40, 12));
  endtask

  // Control codes, wrapping, scrolling, clamping and clear, one at a time.
  task automatic check_control_codes();
    send_request(mk(REQ_PUT, "A", SEL_NORMAL, 0, 0));
    // Other fields of a put are don't-care and go in at all ones.
    send_request(mk(REQ_PUT, 8'hFF, SEL_KERNEL, 127, 31));
    send_request(mk(REQ_PUT, CH_NUL, SEL_PROGRAM, 0, 0));
    send_request(mk(REQ_PUT, CH_BS, SEL_PROGRAM, 0, 0));
    send_request(mk(REQ_READ, CH_NUL, SEL_NORMAL, 1, 0));
    send_request(mk(REQ_PUT, CH_TAB, SEL_NORMAL, 0, 0));
    send_request(mk(REQ_PUT, CH_CR, SEL_NORMAL, 0, 0));
    // Backspace at the left edge.
    send_request(mk(REQ_PUT, CH_BS, SEL_KERNEL, 0, 0));
    send_request(mk(REQ_PUT, CH_LF, SEL_NORMAL, 0, 0));
    // Out-of-range move lands on the bottom-right cell; a put there wraps and scrolls,
    // and selection 3 picks the program colour for both.
    send_request(mk(REQ_MOVE, 8'h55, SEL_KERNEL, 127, 31));
    send_request(mk(REQ_PUT, "Z", SEL_SPARE, 0, 0));
    send_request(mk(REQ_READ, CH_NUL, SEL_NORMAL, 79, 23));
    send_request(mk(REQ_READ, CH_NUL, SEL_NORMAL, 127, 31));
    // Tab from near the right edge starts a new line.
    send_request(mk(REQ_MOVE, CH_NUL, SEL_NORMAL, 75, 3));
    send_request(mk(REQ_PUT, CH_TAB, SEL_NORMAL, 0, 0));
    send_request(mk(REQ_PUT, 8'h01, SEL_KERNEL, 0, 0));
    // Line feed on the bottom row scrolls in the kernel colour.
    send_request(mk(REQ_MOVE, CH_NUL, SEL_NORMAL, 0, 24));
    send_request(mk(REQ_PUT, CH_LF, SEL_KERNEL, 0, 0));
    send_request(mk(REQ_READ, CH_NUL, SEL_NORMAL, 5, 24));
    send_request(mk(REQ_READ, CH_NUL, SEL_NORMAL, 79, 22));
    send_request(mk(REQ_PUT, 8'h80, SEL_SPARE, 0, 0));
    send_request(mk(REQ_CLEAR, 8'hAA, SEL_KERNEL, 42, 21));
    send_request(mk(REQ_READ, CH_NUL, SEL_NORMAL, 40, 12));
    send_request(mk(REQ_READ, CH_NUL, SEL_NORMAL, 0, 4));
  endtask

  // Each palette register at 0 and at 255; the kernel register holds the opposite level of the other two.
  task automatic check_palette_extremes();
    logic [ATTR_W-1:0] level;
    for (int pass = 0; pass < 2; pass++) begin
      level = (pass == 0) ? 8'h00 : 8'hFF;
      drain_results();
      load_palette(level, ~level, level);
      send_request(mk(REQ_CLEAR, CH_NUL, SEL_NORMAL, 0, 0));
      send_request(mk(REQ_PUT, "x", SEL_NORMAL, 0, 0));
      send_request(mk(REQ_PUT, "y", SEL_KERNEL, 0, 0));
      send_request(mk(REQ_PUT, "z", SEL_SPARE, 0, 0));
      send_request(mk(REQ_READ, CH_NUL, SEL_NORMAL, 1, 0));
      send_request(mk(REQ_MOVE, CH_NUL, SEL_NORMAL, 10, 24));
      send_request(mk(REQ_PUT, CH_LF, SEL_NORMAL, 0, 0));
      send_request(mk(REQ_READ, CH_NUL, SEL_NORMAL, 79, 24));
      send_request(mk(REQ_READ, CH_NUL, SEL_NORMAL, 3, 3));
    end
  endtask

  // Random traffic in phases, each with its own palette. Most of it is typing: place the
  // cursor, type a burst of text with control codes mixed in, then read some cells back.
  task automatic check_random_traffic();
    int unsigned       sent;
    int unsigned       pick;
    int unsigned       col;
    int unsigned       row;
    logic [CHAR_W-1:0] code;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      drain_results();
      if (phase == 0) begin
        load_palette(COLOR_NORMAL_RST, COLOR_KERNEL_RST, COLOR_PROGRAM_RST);
      end else begin
        load_palette(ATTR_W'($urandom), ATTR_W'($urandom), ATTR_W'($urandom));
      end
      steady = (phase == 2);
      sent = 0;
      while (sent < PHASE_WORDS) begin
        if ($urandom_range(0, 99) < 70) begin
          col = ($urandom_range(0, 99) < 25) ? $urandom_range(0, 127) : $urandom_range(0, 79);
          row = ($urandom_range(0, 99) < 15) ? $urandom_range(0, 31) : $urandom_range(0, 23);
          send_request(mk(REQ_MOVE, CHAR_W'($urandom), SEL_W'($urandom), col, row));
          sent++;
        end
        repeat ($urandom_range(2, 40)) begin
          pick = $urandom_range(0, 99);
          if (pick < 8) begin
            code = CH_LF;
          end else if (pick < 12) begin
            code = CH_CR;
          end else if (pick < 16) begin
            code = CH_TAB;
          end else if (pick < 21) begin
            code = CH_BS;
          end else if (pick < 23) begin
            code = CH_NUL;
          end else if (pick < 30) begin
            code = CHAR_W'($urandom);
          end else begin
            code = CHAR_W'($urandom_range(8'h20, 8'h7E));
          end
          send_request(limit_sweeps(mk(REQ_PUT, code, SEL_W'($urandom),
                                       $urandom_range(0, 127), $urandom_range(0, 31))));
          if (code != CH_NUL) begin
            sent++;
          end
        end
        // Read back next to the cursor half of the time, anywhere otherwise.
        repeat ($urandom_range(0, 5)) begin
          if ($urandom_range(0, 1) == 0) begin
            col = (cur_col > 0) ? cur_col - 1 : 0;
            row = cur_row;
          end else begin
            col = $urandom_range(0, 127);
            row = $urandom_range(0, 31);
          end
          send_request(mk(REQ_READ, CHAR_W'($urandom), SEL_W'($urandom), col, row));
          sent++;
        end
        if ($urandom_range(0, 99) < 3) begin
          send_request(limit_sweeps(mk(REQ_CLEAR, CHAR_W'($urandom), SEL_W'($urandom),
                                       $urandom_range(0, 127), $urandom_range(0, 31))));
          sent++;
        end
        // Now and then the sender waits for the block to empty out completely.
        if ($urandom_range(0, 99) < 3) begin
          drain_results();
        end
      end
      steady = 1'b0;
    end
  endtask

  initial begin
    // Shadow console at its reset state.
    palette[CFG_COLOR_NORMAL]  = COLOR_NORMAL_RST;
    palette[CFG_COLOR_KERNEL]  = COLOR_KERNEL_RST;
    palette[CFG_COLOR_PROGRAM] = COLOR_PROGRAM_RST;
    fill_screen(CH_NUL, COLOR_PROGRAM_RST);
    cur_col = 0;
    cur_row = 0;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // The block clears its store after reset with the input held off; the first
    // handshake simply waits for that.
    check_reset_state();
    check_control_codes();
    check_palette_extremes();
    check_random_traffic();

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && awaited_resps.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
design/tce_pkg.sv
design/tce_cell_ram.sv
design/tce_sweep.sv
design/text_console_engine.sv
verif/text_console_engine_test.sv
